>>> rtl/sdpg_pkg.sv
package sdpg_pkg;

  // Field widths
  localparam int TB_W    = 27;   // timebase and rate fields
  localparam int STEP_W  = 32;   // signed step count
  localparam int REM_W   = 31;   // step countdown
  localparam int COUNT_WIDTH = 32;  // phase counter and period registers

  // Width used when the period is clamped to the counter range
  localparam int SAT_W = (COUNT_WIDTH > TB_W) ? COUNT_WIDTH : TB_W;

  // Divider iteration count width
  localparam int DIV_CNT_W = $clog2(TB_W + 1);

  localparam logic [TB_W-1:0] TB_RESET = TB_W'(1000000);

  // Command codes
  typedef enum logic [1:0] {
    CMD_MOVE      = 2'd0,
    CMD_STOP_HOLD = 2'd1,
    CMD_STOP_REL  = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_e;

endpackage

>>> rtl/sdpg_div.sv
// Restoring divider, one quotient bit per cycle.
module sdpg_div import sdpg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [TB_W-1:0] dividend_i,
  input  logic [TB_W-1:0] divisor_i,
  output logic            done_o,
  output logic [TB_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [TB_W-1:0]      num_q, num_d;   // dividend shifts out, quotient shifts in
  logic [TB_W-1:0]      rem_q, rem_d;
  logic [TB_W-1:0]      div_q, div_d;
  logic [TB_W:0]        shifted;
  logic [TB_W:0]        trial;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, num_q[TB_W-1]};
    trial   = shifted - {1'b0, div_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(TB_W);
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[TB_W]) begin
        rem_d = shifted[TB_W-1:0];
      end else begin
        rem_d = trial[TB_W-1:0];
      end
      num_d = {num_q[TB_W-2:0], ~trial[TB_W]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

>>> rtl/step_dir_pulse_generator.sv
// Step/direction pulse generator for a stepper driver. Each input transaction
// returns exactly one result transaction. Tick, stop and zero-step move
// commands return their result in the cycle after they are taken, so ticks
// can be sent every clock cycle when the result side does not stall. A move
// with nonzero steps gets its period, timebase_hz / step_rate_hz, from a
// restoring divider at one quotient bit per cycle, started as it is taken;
// the move loads when the divide ends, the input stalling meanwhile. Write
// timebase_hz (cfg_we_i / cfg_wdata_i) while idle; the block does not enforce it.
module step_dir_pulse_generator import sdpg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [TB_W-1:0]          cfg_wdata_i,
  // command channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic signed [STEP_W-1:0] step_count_i,
  input  logic [TB_W-1:0]          step_rate_hz_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     step_level_o,
  output logic                     dir_level_o,
  output logic                     enable_level_o,
  output logic                     busy_res_o,
  output logic                     move_done_o
);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

  state_e state_q, state_d;

  logic [TB_W-1:0]        timebase_q;
  logic [REM_W-1:0]       steps_rem_q, steps_rem_d;
  logic                   moving_q, moving_d;
  logic [COUNT_WIDTH-1:0] period_top_q, period_top_d;
  logic [COUNT_WIDTH-1:0] half_point_q, half_point_d;
  logic [COUNT_WIDTH-1:0] phase_q, phase_d;
  logic                   dir_q, dir_d;
  logic                   enable_q, enable_d;
  logic [REM_W-1:0]       pend_mag_q, pend_mag_d;
  logic                   pend_neg_q, pend_neg_d;

  logic out_valid_q, out_valid_d;
  logic step_q, step_d;
  logic done_q, done_d;
  logic dir_out_q, dir_out_d;
  logic en_out_q, en_out_d;
  logic busy_out_q, busy_out_d;

  logic                   in_accept;
  logic                   div_start;
  logic                   div_done;
  logic [TB_W-1:0]        div_rate;
  logic [TB_W-1:0]        quotient;
  logic [STEP_W-1:0]      cnt_abs;
  logic [REM_W-1:0]       cnt_mag;
  logic [SAT_W-1:0]       period_wide;
  logic [COUNT_WIDTH-1:0] period_new;
  logic [COUNT_WIDTH:0]   half_sum;
  logic [REM_W-1:0]       rem_dec;

  // Handshake: take a command when idle and the result slot is free or draining
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Step count magnitude, saturated to the countdown width
  assign cnt_abs = step_count_i[STEP_W-1] ? (~step_count_i + 1'b1) : step_count_i;
  assign cnt_mag = cnt_abs[STEP_W-1] ? {REM_W{1'b1}} : cnt_abs[REM_W-1:0];

  // Zero rate counts as one
  assign div_rate  = (step_rate_hz_i == '0) ? TB_W'(1) : step_rate_hz_i;
  assign div_start = in_accept && (cmd_e'(command_i) == CMD_MOVE) && (step_count_i != '0);

  sdpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (timebase_q),
    .divisor_i  (div_rate),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Period = quotient - 1, floored at zero and clamped to the counter range
  always_comb begin
    if (quotient == '0) begin
      period_wide = '0;
    end else begin
      period_wide = SAT_W'(quotient) - 1'b1;
    end
    if (period_wide > SAT_W'({COUNT_WIDTH{1'b1}})) begin
      period_new = {COUNT_WIDTH{1'b1}};
    end else begin
      period_new = period_wide[COUNT_WIDTH-1:0];
    end
    half_sum = {1'b0, period_new} + 1'b1;
  end

  assign rem_dec = (steps_rem_q != '0) ? (steps_rem_q - 1'b1) : steps_rem_q;

  // Sequencer and move state
  always_comb begin
    state_d      = state_q;
    steps_rem_d  = steps_rem_q;
    moving_d     = moving_q;
    period_top_d = period_top_q;
    half_point_d = half_point_q;
    phase_d      = phase_q;
    dir_d        = dir_q;
    enable_d     = enable_q;
    pend_mag_d   = pend_mag_q;
    pend_neg_d   = pend_neg_q;
    out_valid_d  = out_valid_q && out_stall_i;
    step_d       = step_q;
    done_d       = done_q;
    dir_out_d    = dir_out_q;
    en_out_d     = en_out_q;
    busy_out_d   = busy_out_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          step_d = 1'b0;
          done_d = 1'b0;
          case (cmd_e'(command_i))
            CMD_MOVE: begin
              if (step_count_i != '0) begin
                pend_mag_d = cnt_mag;
                pend_neg_d = step_count_i[STEP_W-1];
                state_d    = S_DIV;
              end
            end
            CMD_STOP_HOLD, CMD_STOP_REL: begin
              moving_d    = 1'b0;
              steps_rem_d = '0;
              enable_d    = (cmd_e'(command_i) == CMD_STOP_HOLD);
            end
            CMD_TICK: begin
              if (moving_q) begin
                step_d = (phase_q < half_point_q);
                if (phase_q >= period_top_q) begin
                  phase_d     = '0;
                  steps_rem_d = rem_dec;
                  if (rem_dec == '0) begin
                    moving_d = 1'b0;
                    enable_d = 1'b0;
                    done_d   = 1'b1;
                  end
                end else begin
                  phase_d = phase_q + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          // Result follows at once unless a divide is started
          if (state_d == S_IDLE) begin
            out_valid_d = 1'b1;
            dir_out_d   = dir_d;
            en_out_d    = enable_d;
            busy_out_d  = moving_d;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          period_top_d = period_new;
          half_point_d = half_sum[COUNT_WIDTH:1];
          phase_d      = '0;
          dir_d        = pend_neg_q;
          enable_d     = 1'b1;
          steps_rem_d  = pend_mag_q;
          moving_d     = 1'b1;
          out_valid_d  = 1'b1;
          dir_out_d    = pend_neg_q;
          en_out_d     = 1'b1;
          busy_out_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Timebase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timebase_q <= TB_RESET;
    end else if (cfg_we_i) begin
      timebase_q <= cfg_wdata_i;
    end
  end

  // State and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      steps_rem_q  <= '0;
      moving_q     <= 1'b0;
      period_top_q <= '0;
      half_point_q <= '0;
      phase_q      <= '0;
      dir_q        <= 1'b0;
      enable_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      steps_rem_q  <= steps_rem_d;
      moving_q     <= moving_d;
      period_top_q <= period_top_d;
      half_point_q <= half_point_d;
      phase_q      <= phase_d;
      dir_q        <= dir_d;
      enable_q     <= enable_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_mag_q <= pend_mag_d;
    pend_neg_q <= pend_neg_d;
    step_q     <= step_d;
    done_q     <= done_d;
    dir_out_q  <= dir_out_d;
    en_out_q   <= en_out_d;
    busy_out_q <= busy_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign step_level_o   = step_q;
  assign dir_level_o    = dir_out_q;
  assign enable_level_o = en_out_q;
  assign busy_res_o     = busy_out_q;
  assign move_done_o    = done_q;

  // A move in progress always has the driver enabled
  a_moving_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> enable_q)
    else $error("moving with driver disabled");

  // A move in progress always has steps left
  a_moving_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (steps_rem_q != '0))
    else $error("moving with zero steps remaining");

  // The divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  // No result is pending while a divide runs
  a_div_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !out_valid_q)
    else $error("result pending during divide");

  // Half point never passes the period end
  a_half_le_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_point_q <= period_top_q)
    else $error("half point beyond period");

endmodule
